>>> rtl/nearest_codeword_matcher_assert.svh
// Assertion macros for the codeword matcher.
// Each use names its label, a condition and what must hold with it.
`ifndef NEAREST_CODEWORD_MATCHER_ASSERT_SVH
`define NEAREST_CODEWORD_MATCHER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NCM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NCM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/ncm_pkg.sv
package ncm_pkg;

	// Fixed widths of the item and result fields.
	localparam int ID_W      = 4;
	localparam int MC_W      = 4;
	localparam int RATE_W    = 16;
	localparam int SYM_IN_W  = 8;
	localparam int FRAC_BITS = 15;
	localparam int BONUS_MAX = 255;

	// Item operation codes.
	localparam logic OP_WRITE   = 1'b0;
	localparam logic OP_PATTERN = 1'b1;

	// Register indexes on the configuration port.
	typedef enum logic [1:0] {
		REG_ENTRIES = 2'd0,
		REG_LENGTH  = 2'd1,
		REG_BONUS   = 2'd2
	} ncm_reg_t;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DIV   = 4'b1000
	} ncm_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;
		logic cb_write;
		logic sym_load;
		logic issue;
		logic pos_step;
		logic div_start;
		logic out_load;
	} ncm_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_last;
		logic pipe_empty;
		logic grp_last;
		logic div_done;
		logic out_free;
	} ncm_stat_t;

endpackage

>>> rtl/nearest_codeword_matcher.sv
// Channel   Handshake                  Payload
// item      item_valid / item_stall    op, entry, position, symbol
// result    result_valid / result_stall best_entry, mismatch_count, match_rate
// config    APB write / read           entries_in_use, group_length, match_bonus
//
// A codebook write keeps the block idle. A pattern symbol scans the score memory
// one codeword per cycle, then drains the pipeline.
// The last symbol of a group adds the serial divider, one quotient bit per cycle.
// Reset needs no clearing pass: scores restart at the first symbol of each group.
// An item is taken while a result waits; a group end waits until it is taken.
`include "nearest_codeword_matcher_assert.svh"

module nearest_codeword_matcher import ncm_pkg::*; #(
	parameter int ENTRIES     = 16,
	parameter int DIGITS      = 8,
	parameter int SYMBOL_BITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                item_valid,
	output logic                item_stall,
	input  logic                op,
	input  logic [ID_W-1:0]     entry,
	input  logic [2:0]          position,
	input  logic [SYM_IN_W-1:0] symbol,
	output logic                result_valid,
	input  logic                result_stall,
	output logic [ID_W-1:0]     best_entry,
	output logic [MC_W-1:0]     mismatch_count,
	output logic [RATE_W-1:0]   match_rate
);

	logic       cfg_wr;
	logic       cfg_hit;
	ncm_reg_t   reg_sel;
	logic [4:0] entries_q;
	logic [3:0] length_q;
	logic [7:0] bonus_q;
	ncm_cmd_t   cmd;
	ncm_stat_t  st;

	// Register decode; a write to a known register also restarts the group.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_sel = ncm_reg_t'(paddr[3:2]);
	always_comb begin
		unique case (reg_sel)
			REG_ENTRIES: begin
				cfg_hit = cfg_wr;
				prdata  = {27'b0, entries_q};
			end
			REG_LENGTH: begin
				cfg_hit = cfg_wr;
				prdata  = {28'b0, length_q};
			end
			REG_BONUS: begin
				cfg_hit = cfg_wr;
				prdata  = {24'b0, bonus_q};
			end
			default: begin
				cfg_hit = 1'b0;
				prdata  = '0;
			end
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= 5'd16;
			length_q  <= 4'd8;
			bonus_q   <= 8'd4;
		end else if (cfg_wr) begin
			if (reg_sel == REG_ENTRIES) begin
				entries_q <= pwdata[4:0];
			end
			if (reg_sel == REG_LENGTH) begin
				length_q <= pwdata[3:0];
			end
			if (reg_sel == REG_BONUS) begin
				bonus_q <= pwdata[7:0];
			end
		end
	end

	ncm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.op        (op),
		.cfg_wr    (cfg_hit),
		.st        (st),
		.cmd       (cmd),
		.item_stall(item_stall)
	);

	ncm_dp #(
		.ENTRIES    (ENTRIES),
		.DIGITS     (DIGITS),
		.SYMBOL_BITS(SYMBOL_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.entry         (entry),
		.position      (position),
		.symbol        (symbol),
		.cfg_entries   (entries_q),
		.cfg_length    (length_q),
		.cfg_bonus     (bonus_q),
		.result_stall  (result_stall),
		.st            (st),
		.result_valid  (result_valid),
		.best_entry    (best_entry),
		.mismatch_count(mismatch_count),
		.match_rate    (match_rate)
	);

	// A new result never overwrites one that is still waiting.
	`NCM_ASSERT_SAME(a_no_overwrite, cmd.out_load, !(result_valid && result_stall), "result overwritten while stalled")
	// A started division is not reported done in the following cycle.
	`NCM_ASSERT_NEXT(a_div_restart, cmd.div_start, !st.div_done, "divider done too early")
	// After a pattern symbol is taken the block holds off further items.
	`NCM_ASSERT_NEXT(a_busy_after_load, cmd.sym_load, item_stall, "item taken during a scan")

endmodule

>>> rtl/ncm_div.sv
module ncm_div import ncm_pkg::*; #(
	parameter int NW = 19,
	parameter int DW = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [NW-1:0] quo,
	output logic          done
);

	localparam int CW = $clog2(NW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] n_q;
	logic [DW-1:0] r_q;
	logic [DW:0]   shifted;
	logic [DW:0]   trial;
	logic          qbit;
	logic [DW-1:0] r_next;

	// One quotient bit per cycle, restoring long division.
	assign shifted = {r_q, n_q[NW-1]};
	assign trial   = shifted - {1'b0, den};
	assign qbit    = (shifted >= {1'b0, den});
	assign r_next  = qbit ? trial[DW-1:0] : shifted[DW-1:0];

	// Sequencing: a start loads the count, done rises after the last bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// The dividend shifts out at the top while quotient bits shift in below.
	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			r_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[NW-2:0], qbit};
			r_q <= r_next;
		end
	end

	assign quo  = n_q;
	assign done = done_q;

endmodule

>>> rtl/ncm_dp.sv
module ncm_dp import ncm_pkg::*; #(
	parameter int ENTRIES     = 16,
	parameter int DIGITS      = 8,
	parameter int SYMBOL_BITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ncm_cmd_t            cmd,
	input  logic [ID_W-1:0]     entry,
	input  logic [2:0]          position,
	input  logic [SYM_IN_W-1:0] symbol,
	input  logic [4:0]          cfg_entries,
	input  logic [3:0]          cfg_length,
	input  logic [7:0]          cfg_bonus,
	input  logic                result_stall,
	output ncm_stat_t           st,
	output logic                result_valid,
	output logic [ID_W-1:0]     best_entry,
	output logic [MC_W-1:0]     mismatch_count,
	output logic [RATE_W-1:0]   match_rate
);

	localparam int SB       = SYMBOL_BITS;
	localparam int EW       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int PW       = (DIGITS > 1) ? $clog2(DIGITS) : 1;
	localparam int LW       = $clog2(DIGITS + 2);
	localparam int MW       = $clog2(DIGITS + 1);
	localparam int NW       = FRAC_BITS + LW;
	localparam int SYM_MAX  = (1 << SYMBOL_BITS) - 1;
	localparam int STEP_MAX = (SYM_MAX > BONUS_MAX) ? SYM_MAX : BONUS_MAX;
	localparam int SCORE_W  = $clog2(DIGITS * STEP_MAX + 1) + 1;
	localparam int CB_DEPTH = 1 << (EW + PW);

	// Storage.
	logic [SB-1:0]             cb_mem [CB_DEPTH];
	logic signed [SCORE_W-1:0] sc_mem [ENTRIES];
	logic [MW-1:0]             mm_mem [ENTRIES];

	// Configuration after saturation.
	logic [8:0]    ent_x;
	logic [8:0]    used;
	logic [EW-1:0] used_last;
	logic [5:0]    len_x;
	logic [5:0]    len;
	logic [PW-1:0] len_last;
	logic [LW-1:0] len_p1;

	// Control registers.
	logic [EW-1:0] e_q;
	logic [PW-1:0] pos_q;
	logic          v_s1;
	logic          v_s2;
	logic          out_valid_q;

	// Payload registers.
	logic [15:0]               sym_wide;
	logic [SB-1:0]             sym_in;
	logic [SB-1:0]             sym_q;
	logic                      wr_ok;
	logic [EW+PW-1:0]          cb_wa;
	logic [EW-1:0]             e_s1;
	logic [SB-1:0]             cb_s1;
	logic signed [SCORE_W-1:0] sc_rd_s1;
	logic [MW-1:0]             mm_rd_s1;
	logic [EW-1:0]             e_s2;
	logic signed [SCORE_W-1:0] sc_s2;
	logic [MW-1:0]             mm_s2;
	logic [EW-1:0]             best_q;
	logic signed [SCORE_W-1:0] best_sc_q;
	logic [MW-1:0]             best_mm_q;
	logic [ID_W-1:0]           best_entry_q;
	logic [MC_W-1:0]           mismatch_q;
	logic [RATE_W-1:0]         rate_q;

	// Stage one arithmetic.
	logic                      first;
	logic                      match;
	logic [SB-1:0]             diff;
	logic signed [SCORE_W-1:0] base;
	logic signed [SCORE_W-1:0] step;
	logic signed [SCORE_W-1:0] new_sc;
	logic [MW-1:0]             new_mm;

	// Divider hookup.
	logic [LW-1:0] keep;
	logic [NW-1:0] div_num;
	logic [NW-1:0] div_quo;
	logic          div_done;

	// Saturate the entry count to 1..ENTRIES and the length to 1..DIGITS.
	assign ent_x = {4'b0, cfg_entries};
	assign len_x = {2'b0, cfg_length};
	always_comb begin
		if (ent_x == 9'd0) begin
			used = 9'd1;
		end else if (ent_x > 9'(ENTRIES)) begin
			used = 9'(ENTRIES);
		end else begin
			used = ent_x;
		end
		if (len_x == 6'd0) begin
			len = 6'd1;
		end else if (len_x > 6'(DIGITS)) begin
			len = 6'(DIGITS);
		end else begin
			len = len_x;
		end
	end
	assign used_last = EW'(used - 9'd1);
	assign len_last  = PW'(len - 6'd1);
	assign len_p1    = LW'(len + 6'd1);

	// Symbols keep only their low SYMBOL_BITS bits.
	assign sym_wide = {8'b0, symbol};
	assign sym_in   = sym_wide[SB-1:0];

	// Codebook writes outside the store are dropped.
	assign wr_ok = ({5'b0, entry} < 9'(ENTRIES)) && ({3'b0, position} < 6'(DIGITS));
	assign cb_wa = {EW'(entry), PW'(position)};

	// Score update for one entry. The first symbol of a group starts from zero,
	// so a group needs no clearing of the score memory.
	assign first  = (pos_q == '0);
	assign match  = (cb_s1 == sym_q);
	assign diff   = (cb_s1 > sym_q) ? (cb_s1 - sym_q) : (sym_q - cb_s1);
	assign base   = first ? '0 : sc_rd_s1;
	assign step   = match ? (SCORE_W'(0) - SCORE_W'(cfg_bonus)) : SCORE_W'(diff);
	assign new_sc = base + step;
	assign new_mm = (first ? '0 : mm_rd_s1) + MW'(!match);

	// Memory ports: codebook and score reads for the issued entry, writes
	// of codebook items and of updated scores.
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			cb_s1    <= cb_mem[{e_q, pos_q}];
			sc_rd_s1 <= sc_mem[e_q];
			mm_rd_s1 <= mm_mem[e_q];
			e_s1     <= e_q;
		end
		if (cmd.cb_write && wr_ok) begin
			cb_mem[cb_wa] <= sym_in;
		end
		if (v_s1) begin
			sc_mem[e_s1] <= new_sc;
			mm_mem[e_s1] <= new_mm;
		end
	end

	// Scan counter, group position, stage valids and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_q         <= '0;
			pos_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			if (cmd.sym_load) begin
				e_q <= '0;
			end else if (cmd.issue) begin
				e_q <= e_q + EW'(1);
			end
			if (cmd.clear) begin
				pos_q <= '0;
			end else if (cmd.pos_step) begin
				pos_q <= (pos_q == len_last) ? '0 : pos_q + PW'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Pattern symbol, second stage and running minimum (lowest index on ties).
	always_ff @(posedge clk) begin
		if (cmd.sym_load) begin
			sym_q <= sym_in;
		end
		sc_s2 <= new_sc;
		mm_s2 <= new_mm;
		e_s2  <= e_s1;
		if (v_s2 && ((e_s2 == '0) || (sc_s2 < best_sc_q))) begin
			best_q    <= e_s2;
			best_sc_q <= sc_s2;
			best_mm_q <= mm_s2;
		end
		if (cmd.out_load) begin
			best_entry_q <= ID_W'(best_q);
			mismatch_q   <= MC_W'(best_mm_q);
			rate_q       <= div_quo[RATE_W-1:0];
		end
	end

	// Match rate: floor(2^15 * (len + 1 - m) / (len + 1)).
	assign keep    = len_p1 - LW'(best_mm_q);
	assign div_num = {keep, FRAC_BITS'(0)};

	ncm_div #(
		.NW(NW),
		.DW(LW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (div_num),
		.den   (len_p1),
		.quo   (div_quo),
		.done  (div_done)
	);

	// Status back to the controller.
	assign st.scan_last  = (e_q == used_last);
	assign st.pipe_empty = !v_s1 && !v_s2;
	assign st.grp_last   = (pos_q == len_last);
	assign st.div_done   = div_done;
	assign st.out_free   = !out_valid_q || !result_stall;

	assign result_valid   = out_valid_q;
	assign best_entry     = best_entry_q;
	assign mismatch_count = mismatch_q;
	assign match_rate     = rate_q;

endmodule

>>> rtl/ncm_ctrl.sv
module ncm_ctrl import ncm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	input  logic      op,
	input  logic      cfg_wr,
	input  ncm_stat_t st,
	output ncm_cmd_t  cmd,
	output logic      item_stall
);

	ncm_state_t state_q;
	ncm_state_t state_d;
	logic       accept;

	// Items are taken only between scans.
	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;

	// Next state and commands.
	always_comb begin
		cmd       = '0;
		cmd.clear = cfg_wr;
		state_d   = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (op == OP_PATTERN) begin
						cmd.sym_load = 1'b1;
						state_d      = ST_SCAN;
					end else begin
						cmd.cb_write = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				cmd.issue = 1'b1;
				if (st.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (st.pipe_empty) begin
					cmd.pos_step = 1'b1;
					if (st.grp_last) begin
						cmd.div_start = 1'b1;
						state_d       = ST_DIV;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_DIV: begin
				if (st.div_done && st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
